// ===== rtl/i2cw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cw_pkg
// Types and constants shared by the write-only I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cw_pkg;

    localparam logic [7:0] MSB_MASK      = 8'h80;
    localparam logic       ACT_TICK      = 1'b0;
    localparam logic       ACT_SUBMIT    = 1'b1;
    localparam logic       SKIP_NACK_RST = 1'b1;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_START = 7'b0000010,
        PH_GAP   = 7'b0000100,
        PH_DATA  = 7'b0001000,
        PH_ACK   = 7'b0010000,
        PH_WAIT  = 7'b0100000,
        PH_STOP  = 7'b1000000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  half_step;
        logic [2:0]  bit_count;
        logic [7:0]  shift_byte;
        logic        stop_after;
        logic        error_flag;
        logic        sda_level;
        logic        scl_level;
    } state_t;

    typedef struct packed {
        logic        action;
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic        sda_in;
    } in_item_t;

    typedef struct packed {
        logic scl_release;
        logic sda_release;
        logic byte_accepted;
        logic ready_for_byte;
        logic frame_open;
        logic ack_valid;
        logic ack_bit;
        logic frame_done;
        logic frame_error;
    } out_item_t;

    localparam state_t STATE_RST = '{
        phase:      PH_IDLE,
        half_step:  2'd0,
        bit_count:  3'd0,
        shift_byte: 8'd0,
        stop_after: 1'b0,
        error_flag: 1'b0,
        sda_level:  1'b1,
        scl_level:  1'b1
    };

endpackage
`default_nettype wire

// ===== rtl/i2cw_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cw_in_if
// Input item channel: tick or byte submit, valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2cw_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       sda_in;

    modport source (
        output valid, action, data_byte, first_byte, last_byte, sda_in,
        input  ready
    );
    modport sink (
        input  valid, action, data_byte, first_byte, last_byte, sda_in,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/i2cw_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cw_out_if
// Result channel: line levels and status for each item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2cw_out_if;
    logic valid;
    logic ready;
    logic scl_release;
    logic sda_release;
    logic byte_accepted;
    logic ready_for_byte;
    logic frame_open;
    logic ack_valid;
    logic ack_bit;
    logic frame_done;
    logic frame_error;

    modport source (
        output valid, scl_release, sda_release, byte_accepted, ready_for_byte,
               frame_open, ack_valid, ack_bit, frame_done, frame_error,
        input  ready
    );
    modport sink (
        input  valid, scl_release, sda_release, byte_accepted, ready_for_byte,
               frame_open, ack_valid, ack_bit, frame_done, frame_error,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/i2cw_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cw_cfg_if
// Configuration write channel carrying the skip_nack register value.
// ----------------------------------------------------------------------------
interface i2cw_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/i2c_master_write_bit_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_write_bit_engine
// Write-only I2C master stepped one half period of SCL per tick item.
//
// The item channel carries ticks (action 0, with the sensed sda_in level) and
// byte submits (action 1, with data_byte, first_byte, last_byte). Every item
// yields exactly one result on the result channel: the SCL/SDA levels to drive
// for that half period plus status (byte_accepted, ready_for_byte, frame_open,
// ack_valid/ack_bit, frame_done/frame_error).
// Items land in an input register; the combinational step logic then updates the
// engine state and the result register. A result passes through the input
// register and then the result register; one item per cycle is sustained while
// result.ready is high, set by the single state update per item.
// While a result waits the input register still takes one item; the input
// stalls when both the input and result registers are full and result.ready
// is low. The cfg channel writes skip_nack (reset 1) and is always ready;
// write it only while no item is in flight.
// Reset puts the engine idle with both lines released and empties both
// registers; no results are pending after reset.
// ----------------------------------------------------------------------------
module i2c_master_write_bit_engine (
    input  logic              clk,
    input  logic              rst_n,
    i2cw_in_if.sink           item,
    i2cw_out_if.source        result,
    i2cw_cfg_if.sink          cfg
);

    i2cw_pkg::in_item_t  in_item_reg;
    logic                in_valid_reg;
    i2cw_pkg::state_t    state_reg;
    i2cw_pkg::state_t    state_next;
    i2cw_pkg::out_item_t res_reg;
    i2cw_pkg::out_item_t res_next;
    logic                res_valid_reg;
    logic                skip_nack_reg;
    logic                advance;

    // step the engine when the result slot is free or draining this cycle
    assign advance    = in_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    i2cw_step u_step (
        .st        (state_reg),
        .item      (in_item_reg),
        .skip_nack (skip_nack_reg),
        .st_next   (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= i2cw_pkg::STATE_RST;
            skip_nack_reg <= i2cw_pkg::SKIP_NACK_RST;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                skip_nack_reg <= cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_item_reg.action     <= item.action;
            in_item_reg.data_byte  <= item.data_byte;
            in_item_reg.first_byte <= item.first_byte;
            in_item_reg.last_byte  <= item.last_byte;
            in_item_reg.sda_in     <= item.sda_in;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.scl_release    = res_reg.scl_release;
    assign result.sda_release    = res_reg.sda_release;
    assign result.byte_accepted  = res_reg.byte_accepted;
    assign result.ready_for_byte = res_reg.ready_for_byte;
    assign result.frame_open     = res_reg.frame_open;
    assign result.ack_valid      = res_reg.ack_valid;
    assign result.ack_bit        = res_reg.ack_bit;
    assign result.frame_done     = res_reg.frame_done;
    assign result.frame_error    = res_reg.frame_error;

    a_done_closes_frame: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.frame_done |-> res_reg.ready_for_byte && !res_reg.frame_open
    ) else $error("frame_done reported with the frame still open");

    a_ack_bit_qualified: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.ack_valid |-> !res_reg.ack_bit
    ) else $error("ack_bit set without ack_valid");

    a_half_step_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        state_reg.half_step != 2'd3
    ) else $error("half_step out of range");

    a_advance_fills_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg
    ) else $error("stepped item produced no result");

    a_error_only_on_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.frame_error |-> res_reg.frame_done
    ) else $error("frame_error without frame_done");

endmodule
`default_nettype wire

// ===== rtl/i2cw_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cw_step
// Next state and result for one item: a half-period tick or a byte submit.
// ----------------------------------------------------------------------------
module i2cw_step (
    input  i2cw_pkg::state_t    st,
    input  i2cw_pkg::in_item_t  item,
    input  logic                skip_nack,
    output i2cw_pkg::state_t    st_next,
    output i2cw_pkg::out_item_t res
);

    logic data_bit;

    assign data_bit = (st.shift_byte & i2cw_pkg::MSB_MASK) != 8'd0;

    always_comb
    begin
        st_next = st;
        res     = '0;

        if (item.action == i2cw_pkg::ACT_SUBMIT)
        begin
            if ((st.phase == i2cw_pkg::PH_IDLE && item.first_byte) ||
                (st.phase == i2cw_pkg::PH_WAIT && !item.first_byte))
            begin
                res.byte_accepted  = 1'b1;
                st_next.shift_byte = item.data_byte;
                st_next.stop_after = item.last_byte;
                st_next.half_step  = 2'd0;
                st_next.bit_count  = 3'd0;
                st_next.phase      = (st.phase == i2cw_pkg::PH_IDLE) ?
                                     i2cw_pkg::PH_START : i2cw_pkg::PH_GAP;
            end
        end
        else
        begin
            unique case (st.phase)
                i2cw_pkg::PH_START:
                begin
                    st_next.sda_level = 1'b0;
                    if (st.half_step == 2'd0)
                    begin
                        st_next.scl_level = 1'b1;
                        st_next.half_step = 2'd1;
                    end
                    else
                    begin
                        st_next.scl_level = 1'b0;
                        st_next.half_step = 2'd0;
                        st_next.bit_count = 3'd0;
                        st_next.phase     = i2cw_pkg::PH_DATA;
                    end
                end
                i2cw_pkg::PH_GAP:
                begin
                    st_next.scl_level = 1'b0;
                    if (st.half_step == 2'd0)
                    begin
                        st_next.half_step = 2'd1;
                    end
                    else
                    begin
                        st_next.half_step = 2'd0;
                        st_next.bit_count = 3'd0;
                        st_next.phase     = i2cw_pkg::PH_DATA;
                    end
                end
                i2cw_pkg::PH_DATA:
                begin
                    st_next.sda_level = data_bit;
                    if (st.half_step == 2'd0)
                    begin
                        st_next.scl_level = 1'b0;
                        st_next.half_step = 2'd1;
                    end
                    else
                    begin
                        st_next.scl_level  = 1'b1;
                        st_next.half_step  = 2'd0;
                        st_next.shift_byte = {st.shift_byte[6:0], 1'b0};
                        if (st.bit_count == 3'd7)
                        begin
                            st_next.bit_count = 3'd0;
                            st_next.phase     = i2cw_pkg::PH_ACK;
                        end
                        else
                        begin
                            st_next.bit_count = st.bit_count + 3'd1;
                        end
                    end
                end
                i2cw_pkg::PH_ACK:
                begin
                    st_next.sda_level = 1'b1;
                    if (st.half_step == 2'd0)
                    begin
                        st_next.scl_level = 1'b0;
                        st_next.half_step = 2'd1;
                    end
                    else
                    begin
                        // acknowledge sampled while scl is high
                        st_next.scl_level = 1'b1;
                        st_next.half_step = 2'd0;
                        res.ack_valid     = 1'b1;
                        res.ack_bit       = item.sda_in;
                        if (item.sda_in && !skip_nack)
                        begin
                            st_next.error_flag = 1'b1;
                            st_next.phase      = i2cw_pkg::PH_STOP;
                        end
                        else if (st.stop_after)
                        begin
                            st_next.phase = i2cw_pkg::PH_STOP;
                        end
                        else
                        begin
                            st_next.phase = i2cw_pkg::PH_WAIT;
                        end
                    end
                end
                i2cw_pkg::PH_WAIT:
                begin
                    st_next.scl_level = 1'b0;
                end
                i2cw_pkg::PH_STOP:
                begin
                    if (st.half_step == 2'd0)
                    begin
                        st_next.scl_level = 1'b0;
                        st_next.sda_level = 1'b0;
                        st_next.half_step = 2'd1;
                    end
                    else if (st.half_step == 2'd1)
                    begin
                        st_next.scl_level = 1'b1;
                        st_next.sda_level = 1'b0;
                        st_next.half_step = 2'd2;
                    end
                    else
                    begin
                        st_next.scl_level  = 1'b1;
                        st_next.sda_level  = 1'b1;
                        st_next.half_step  = 2'd0;
                        res.frame_done     = 1'b1;
                        res.frame_error    = st.error_flag;
                        st_next.error_flag = 1'b0;
                        st_next.stop_after = 1'b0;
                        st_next.phase      = i2cw_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    // idle, or a corrupted phase code: release the bus
                    st_next.scl_level = 1'b1;
                    st_next.sda_level = 1'b1;
                    st_next.half_step = 2'd0;
                    st_next.phase     = i2cw_pkg::PH_IDLE;
                end
            endcase
        end

        res.scl_release    = st_next.scl_level;
        res.sda_release    = st_next.sda_level;
        res.ready_for_byte = (st_next.phase == i2cw_pkg::PH_IDLE) ||
                             (st_next.phase == i2cw_pkg::PH_WAIT);
        res.frame_open     = (st_next.phase != i2cw_pkg::PH_IDLE);
    end

endmodule
`default_nettype wire
